/* sv/ccpt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccpt_pkg
// Types and constants shared by the cheat code patch table blocks.
// ----------------------------------------------------------------------------
package ccpt_pkg;

	typedef enum logic [2:0] {
		REQ_ADD     = 3'd0,
		REQ_REMOVE  = 3'd1,
		REQ_ENABLE  = 3'd2,
		REQ_DISABLE = 3'd3,
		REQ_VBLANK  = 3'd4,
		REQ_CLEAR   = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ACT_NONE      = 2'd0,
		ACT_WRITE     = 2'd1,
		ACT_RAM_BANK  = 2'd2,
		ACT_WRAM_BANK = 2'd3
	} action_t;

	localparam logic [7:0] TYPE_PLAIN   = 8'h01;
	localparam logic [3:0] HI_RAM_BANK  = 4'h8;
	localparam logic [3:0] HI_WRAM_BANK = 4'h9;
	localparam int         CODE_CHARS   = 8;
	localparam logic [7:0] CODE_LEN     = 8'd8;
	localparam int         MAX_RESULTS  = 16;
	localparam int         RES_CNT_W    = $clog2(MAX_RESULTS + 1);

	// classified command handed from front to back
	typedef struct packed {
		logic [2:0]  req;
		logic        bad;
		logic [31:0] id;
		action_t     kind;
		logic [3:0]  bank;
		logic [7:0]  value;
		logic [15:0] addr;
	} cmd_t;

	typedef struct packed {
		logic [31:0] id;
		action_t     kind;
		logic [3:0]  bank;
		logic [7:0]  value;
		logic [15:0] addr;
		logic        en;
	} entry_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] new_id;
		action_t     action;
		logic [3:0]  bank_number;
		logic [15:0] patch_addr;
		logic [7:0]  patch_value;
		logic        last;
	} res_t;

	// {bad, nibble}
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = {1'b1, 4'h0};
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c inside {[8'h41:8'h46]}) begin
			r = {1'b0, 4'(c - 8'h37)};
		end else if (c inside {[8'h61:8'h66]}) begin
			r = {1'b0, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* sv/ccpt_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccpt request / response interfaces
// Valid/ready channels carrying requests into and results out of the table.
// ----------------------------------------------------------------------------
interface ccpt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [63:0] code_chars;
	logic [7:0]  code_length;
	logic [31:0] cheat_id;

	modport source (output valid, req_type, code_chars, code_length, cheat_id,
		input ready);
	modport sink (input valid, req_type, code_chars, code_length, cheat_id,
		output ready);
endinterface

interface ccpt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] new_id;
	logic [1:0]  action;
	logic [3:0]  bank_number;
	logic [15:0] patch_addr;
	logic [7:0]  patch_value;
	logic        last;

	modport source (output valid, status, new_id, action, bank_number, patch_addr,
		patch_value, last, input ready);
	modport sink (input valid, status, new_id, action, bank_number, patch_addr,
		patch_value, last, output ready);
endinterface
`default_nettype wire

/* sv/cheat_code_patch_table_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cheat_code_patch_table_unit
// Ordered table of memory-patch cheat codes with add, remove, enable,
// disable, clear and a vblank pass that emits one patch per enabled entry.
//
//   channel  dir  fields                                         end of
//   req      in   req_type code_chars code_length cheat_id       one request
//   rsp      out  status new_id action bank_number patch_addr
//                 patch_value last                               last=1
//
// Add, clear and unused request codes answer without a table walk.
// Remove/enable/disable/vblank walk the table through the single read port,
// one entry per cycle: a miss answers after the last entry has been read, and
// a hit on entry i answers as soon as that entry is read. A found remove first
// shifts the later entries down and then answers.
// Vblank pauses while the result register is held by a stalled sink.
// Reset clears the count but not the table contents, which need no clearing pass.
// ----------------------------------------------------------------------------
module cheat_code_patch_table_unit #(
	parameter int MAX_CHEATS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	ccpt_req_if.sink   req,
	ccpt_rsp_if.source rsp
);

	logic           push_vld;
	logic           push_rdy;
	ccpt_pkg::cmd_t push_cmd;
	logic           pop_vld;
	logic           pop_rdy;
	ccpt_pkg::cmd_t pop_cmd;

	ccpt_front u_front (
		.req      (req),
		.push_vld (push_vld),
		.push_rdy (push_rdy),
		.push_cmd (push_cmd)
	);

	ccpt_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_vld (push_vld),
		.push_rdy (push_rdy),
		.push_cmd (push_cmd),
		.pop_vld  (pop_vld),
		.pop_rdy  (pop_rdy),
		.pop_cmd  (pop_cmd)
	);

	ccpt_back #(
		.MAX_CHEATS (MAX_CHEATS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_vld (pop_vld),
		.cmd_rdy (pop_rdy),
		.cmd     (pop_cmd),
		.rsp     (rsp)
	);

endmodule
`default_nettype wire

/* sv/ccpt_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccpt_front
// Accepts requests, parses add codes and classifies them into commands.
// ----------------------------------------------------------------------------
module ccpt_front (
	ccpt_req_if.sink       req,
	output logic           push_vld,
	input  logic           push_rdy,
	output ccpt_pkg::cmd_t push_cmd
);

	logic [4:0]  nib [ccpt_pkg::CODE_CHARS];
	logic [31:0] code_id;
	logic        char_bad;
	logic [7:0]  code_type;

	always_comb begin
		char_bad = 1'b0;
		code_id  = '0;
		for (int i = 0; i < ccpt_pkg::CODE_CHARS; i++) begin
			nib[i]           = ccpt_pkg::hex_nibble(req.code_chars[8*i +: 8]);
			char_bad         = char_bad | nib[i][4];
			code_id[4*i +: 4] = nib[i][3:0];
		end
	end

	assign code_type = {nib[0][3:0], nib[1][3:0]};

	always_comb begin
		push_cmd       = '0;
		push_cmd.req   = req.req_type;
		push_cmd.bank  = nib[1][3:0];
		push_cmd.value = {nib[2][3:0], nib[3][3:0]};
		push_cmd.addr  = {nib[6][3:0], nib[7][3:0], nib[4][3:0], nib[5][3:0]};
		push_cmd.kind  = ccpt_pkg::ACT_NONE;
		if (code_type == ccpt_pkg::TYPE_PLAIN) begin
			push_cmd.kind = ccpt_pkg::ACT_WRITE;
		end else if (code_type[7:4] == ccpt_pkg::HI_RAM_BANK) begin
			push_cmd.kind = ccpt_pkg::ACT_RAM_BANK;
		end else if (code_type[7:4] == ccpt_pkg::HI_WRAM_BANK) begin
			push_cmd.kind = ccpt_pkg::ACT_WRAM_BANK;
		end
		if (req.req_type == ccpt_pkg::REQ_ADD) begin
			push_cmd.id  = code_id;
			push_cmd.bad = char_bad || (req.code_length != ccpt_pkg::CODE_LEN) ||
				(push_cmd.kind == ccpt_pkg::ACT_NONE);
		end else begin
			push_cmd.id = req.cheat_id;
		end
	end

	assign push_vld  = req.valid;
	assign req.ready = push_rdy;

endmodule
`default_nettype wire

/* sv/ccpt_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccpt_cmd_fifo
// Two-entry command queue between the front and back sections.
// ----------------------------------------------------------------------------
module ccpt_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_vld,
	output logic           push_rdy,
	input  ccpt_pkg::cmd_t push_cmd,
	output logic           pop_vld,
	input  logic           pop_rdy,
	output ccpt_pkg::cmd_t pop_cmd
);

	ccpt_pkg::cmd_t buf_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;

	assign push_rdy = (cnt_q != 2'd2);
	assign pop_vld  = (cnt_q != 2'd0);
	assign pop_cmd  = buf_q[rp_q];
	assign push     = push_vld && push_rdy;
	assign pop      = pop_vld && pop_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

/* sv/ccpt_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccpt_back
// Executes commands against the cheat table memory: append, search, shift on
// remove, flag update, clear, and the vblank walk that emits patch results.
// ----------------------------------------------------------------------------
module ccpt_back #(
	parameter int MAX_CHEATS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_vld,
	output logic           cmd_rdy,
	input  ccpt_pkg::cmd_t cmd,
	ccpt_rsp_if.source     rsp
);

	localparam int IDX_W = (MAX_CHEATS > 1) ? $clog2(MAX_CHEATS) : 1;
	localparam int CNT_W = $clog2(MAX_CHEATS + 1);
	localparam int RCW   = ccpt_pkg::RES_CNT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_RESP
	} state_t;

	state_t           st_q;
	ccpt_pkg::cmd_t   cmd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] scan_q;
	logic             chk_vld_s1;
	logic [IDX_W-1:0] chk_idx_s1;
	ccpt_pkg::entry_t rdata_q;
	ccpt_pkg::entry_t mem [MAX_CHEATS];
	logic [RCW-1:0]   n_q;
	logic             pend_vld_q;
	ccpt_pkg::res_t   pend_q;
	ccpt_pkg::res_t   resp_q;
	logic             out_vld_q;
	ccpt_pkg::res_t   out_q;

	logic             out_free;
	logic             is_vb;
	logic             can_issue;
	logic             hit;
	logic             found;
	logic             stall;
	logic             scan_stop;
	logic             issue;
	logic             out_load;
	logic             we;
	logic [IDX_W-1:0] waddr;
	ccpt_pkg::entry_t wdata;
	logic [CNT_W-1:0] scan_m1;
	ccpt_pkg::res_t   vres;
	ccpt_pkg::res_t   vres_last;
	ccpt_pkg::res_t   pend_last;
	ccpt_pkg::res_t   res_ok;
	ccpt_pkg::res_t   res_add;
	ccpt_pkg::res_t   out_d;

	assign out_free  = !out_vld_q || rsp.ready;
	assign cmd_rdy   = (st_q == ST_IDLE);
	assign is_vb     = (cmd_q.req == ccpt_pkg::REQ_VBLANK);
	assign can_issue = (scan_q < cnt_q);
	assign hit       = chk_vld_s1 && (rdata_q.id == cmd_q.id);
	assign found     = chk_vld_s1 && rdata_q.en;
	assign stall     = (st_q == ST_SCAN) && is_vb && found && pend_vld_q && !out_free;
	assign scan_stop = is_vb ? (found && (n_q == RCW'(ccpt_pkg::MAX_RESULTS - 1))) : hit;
	assign issue     = ((st_q == ST_SCAN) && can_issue && !stall && !scan_stop) ||
		((st_q == ST_SHIFT) && can_issue);
	assign out_load  = ((st_q == ST_SCAN) && is_vb && found && !stall && pend_vld_q) ||
		((st_q == ST_RESP) && out_free);
	assign out_d     = (st_q == ST_RESP) ? resp_q : pend_q;
	assign scan_m1   = scan_q - CNT_W'(1);

	always_comb begin
		res_ok        = '0;
		res_ok.status = ccpt_pkg::ST_OK;
		res_ok.action = ccpt_pkg::ACT_NONE;
		res_ok.last   = 1'b1;
		res_add       = res_ok;
		if (cmd.bad) begin
			res_add.status = ccpt_pkg::ST_INVALID;
		end else if (cnt_q >= CNT_W'(MAX_CHEATS)) begin
			res_add.status = ccpt_pkg::ST_FULL;
		end else begin
			res_add.new_id = cmd.id;
		end
		vres             = '0;
		vres.status      = ccpt_pkg::ST_OK;
		vres.action      = rdata_q.kind;
		vres.bank_number = (rdata_q.kind == ccpt_pkg::ACT_WRITE) ? 4'h0 : rdata_q.bank;
		vres.patch_addr  = rdata_q.addr;
		vres.patch_value = rdata_q.value;
		vres_last        = vres;
		vres_last.last   = 1'b1;
		pend_last        = pend_q;
		pend_last.last   = 1'b1;
	end

	always_comb begin
		we    = 1'b0;
		waddr = chk_idx_s1;
		wdata = rdata_q;
		case (st_q)
			ST_IDLE: begin
				waddr = cnt_q[IDX_W-1:0];
				wdata = {cmd.id, cmd.kind, cmd.bank, cmd.value, cmd.addr, 1'b1};
				we    = cmd_vld && (cmd.req == ccpt_pkg::REQ_ADD) && !cmd.bad &&
					(cnt_q < CNT_W'(MAX_CHEATS));
			end
			ST_SCAN: begin
				wdata.en = (cmd_q.req == ccpt_pkg::REQ_ENABLE);
				we       = hit && ((cmd_q.req == ccpt_pkg::REQ_ENABLE) ||
					(cmd_q.req == ccpt_pkg::REQ_DISABLE));
			end
			ST_SHIFT: begin
				we = chk_vld_s1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_q <= mem[scan_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			cmd_q      <= '0;
			cnt_q      <= '0;
			scan_q     <= '0;
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
			n_q        <= '0;
			pend_vld_q <= 1'b0;
			pend_q     <= '0;
			resp_q     <= '0;
			out_vld_q  <= 1'b0;
			out_q      <= '0;
		end else begin
			if (out_load) begin
				out_q     <= out_d;
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (issue) begin
				scan_q     <= scan_q + CNT_W'(1);
				chk_vld_s1 <= 1'b1;
				chk_idx_s1 <= (st_q == ST_SHIFT) ? scan_m1[IDX_W-1:0] :
					scan_q[IDX_W-1:0];
			end else if (!stall) begin
				chk_vld_s1 <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (cmd_vld) begin
						cmd_q      <= cmd;
						scan_q     <= '0;
						n_q        <= '0;
						pend_vld_q <= 1'b0;
						resp_q     <= (cmd.req == ccpt_pkg::REQ_ADD) ? res_add : res_ok;
						case (cmd.req)
							ccpt_pkg::REQ_ADD: begin
								st_q <= ST_RESP;
								if (!cmd.bad && (cnt_q < CNT_W'(MAX_CHEATS))) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							ccpt_pkg::REQ_REMOVE, ccpt_pkg::REQ_ENABLE,
							ccpt_pkg::REQ_DISABLE, ccpt_pkg::REQ_VBLANK: begin
								st_q <= ST_SCAN;
							end
							ccpt_pkg::REQ_CLEAR: begin
								cnt_q <= '0;
								st_q  <= ST_RESP;
							end
							default: begin
								st_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (is_vb) begin
						if (found && !stall) begin
							n_q <= n_q + RCW'(1);
							if (scan_stop) begin
								resp_q     <= vres_last;
								pend_vld_q <= 1'b0;
								st_q       <= ST_RESP;
							end else begin
								pend_q     <= vres;
								pend_vld_q <= 1'b1;
							end
						end else if (!chk_vld_s1 && !can_issue) begin
							if (pend_vld_q) begin
								resp_q <= pend_last;
							end
							pend_vld_q <= 0;
							st_q       <= ST_RESP;
						end
					end else begin
						if (hit) begin
							st_q <= (cmd_q.req == ccpt_pkg::REQ_REMOVE) ? ST_SHIFT : ST_RESP;
						end else if (!chk_vld_s1 && !can_issue) begin
							resp_q.status <= ccpt_pkg::ST_NOT_FOUND;
							st_q          <= ST_RESP;
						end
					end
				end
				ST_SHIFT: begin
					if (!chk_vld_s1 && !can_issue) begin
						cnt_q <= cnt_q - CNT_W'(1);
						st_q  <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_q.status;
	assign rsp.new_id      = out_q.new_id;
	assign rsp.action      = out_q.action;
	assign rsp.bank_number = out_q.bank_number;
	assign rsp.patch_addr  = out_q.patch_addr;
	assign rsp.patch_value = out_q.patch_value;
	assign rsp.last        = out_q.last;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_CHEATS))
		else $error("entry count above table depth");

	a_chk_state: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> (st_q == ST_SCAN || st_q == ST_SHIFT))
		else $error("read pipeline active outside a table walk");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (st_q != ST_RESP))
		else $error("table write while presenting a result");

	a_pend_vb: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> (st_q == ST_SCAN && cmd_q.req == ccpt_pkg::REQ_VBLANK))
		else $error("held patch outside a vblank walk");

	a_out_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !rsp.ready) |=> (out_vld_q && $stable(out_q)))
		else $error("pending result overwritten");

endmodule
`default_nettype wire

/* bench/tb_cheat_code_patch_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cheat_code_patch_table_unit
// Self-checking bench for the cheat code patch table. A scoreboard keeps its
// own copy of the table and predicts the response transactions for every
// accepted request. Responses are checked in order, field by field. A
// directed pass covers code parsing corner cases, lookups and the vblank
// pass. Random requests follow, with idle cycles and back-pressure.
// ----------------------------------------------------------------------------
module tb_cheat_code_patch_table_unit;
	import ccpt_pkg::*;

	localparam int         TABLE_DEPTH  = 16;
	localparam int         RANDOM_ITEMS = 355;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         DRAIN_CYCLES = 64;
	localparam int         IDLE_PCT     = 17;
	localparam int         MAX_REPORTS  = 10;
	localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
	localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

	typedef struct packed {
		logic [31:0] id;
		action_t     kind;
		logic [3:0]  bank;
		logic [7:0]  value;
		logic [15:0] addr;
		logic        en;
	} cheat_entry_t;

	logic clk;
	logic arst_n;
	logic no_idle;
	int   cycles;
	res_t observed;

	ccpt_req_if req_if();
	ccpt_rsp_if rsp_if();

	cheat_code_patch_table_unit #(
		.MAX_CHEATS(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	function automatic int hex_value(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
		return -1;
	endfunction

	// random letter case
	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	// nibble i of nibs becomes character i
	function automatic logic [63:0] chars_from_nibbles(logic [31:0] nibs);
		logic [63:0] r;
		for (int i = 0; i < CODE_CHARS; i++) r[8*i +: 8] = hex_char(nibs[4*i +: 4]);
		return r;
	endfunction

	function automatic logic [63:0] pack_text(string s);
		logic [63:0] r;
		for (int i = 0; i < CODE_CHARS; i++) r[8*i +: 8] = s[i];
		return r;
	endfunction

	function automatic logic [31:0] id_of_text(string s);
		logic [31:0] r;
		for (int i = 0; i < CODE_CHARS; i++) r[4*i +: 4] = 4'(hex_value(s[i]));
		return r;
	endfunction

	class patch_scoreboard;
		cheat_entry_t entries[TABLE_DEPTH];
		int           count;
		res_t         pending[$];
		int           failures;
		int           checked;
		int           patches;
		int           peak_fill;
		int           req_seen[8];
		int           status_seen[4];

		function void report(string what, res_t want, res_t got);
			failures++;
			if (failures <= MAX_REPORTS)
				$display("[%0t] %s: exp st=%0d id=%h act=%0d bank=%h addr=%h val=%h last=%b",
					$time, what, want.status, want.new_id, want.action, want.bank_number,
					want.patch_addr, want.patch_value, want.last);
			if (failures <= MAX_REPORTS)
				$display("    got st=%0d id=%h act=%0d bank=%h addr=%h val=%h last=%b",
					got.status, got.new_id, got.action, got.bank_number,
					got.patch_addr, got.patch_value, got.last);
		endfunction

		function int find_first(logic [31:0] id);
			for (int i = 0; i < count; i++)
				if (entries[i].id == id) return i;
			return -1;
		endfunction

		function logic [31:0] pick_id();
			if (count == 0 || $urandom_range(0, 4) == 0) return $urandom;
			return entries[$urandom_range(0, count - 1)].id;
		endfunction

		function status_t decode_add(logic [63:0] chars, logic [7:0] len,
			output logic [31:0] id);
			logic [31:0] nibs;
			logic [7:0]  code_type;
			action_t     act;
			int          v;
			id = '0;
			if (len != CODE_LEN) return ST_INVALID;
			for (int i = 0; i < CODE_CHARS; i++) begin
				v = hex_value(chars[8*i +: 8]);
				if (v < 0) return ST_INVALID;
				nibs[4*i +: 4] = 4'(v);
			end
			code_type = {nibs[3:0], nibs[7:4]};
			if (code_type == TYPE_PLAIN) act = ACT_WRITE;
			else if (code_type[7:4] == HI_RAM_BANK) act = ACT_RAM_BANK;
			else if (code_type[7:4] == HI_WRAM_BANK) act = ACT_WRAM_BANK;
			else return ST_INVALID;
			if (count >= TABLE_DEPTH) return ST_FULL;
			entries[count].id    = nibs;
			entries[count].kind  = act;
			entries[count].bank  = nibs[7:4];
			entries[count].value = {nibs[11:8], nibs[15:12]};
			entries[count].addr  = {nibs[27:24], nibs[31:28], nibs[19:16], nibs[23:20]};
			entries[count].en    = 1'b1;
			count++;
			id = nibs;
			return ST_OK;
		endfunction

		function void note_request(logic [2:0] rq, logic [63:0] chars, logic [7:0] len,
			logic [31:0] cid);
			res_t        r;
			logic [31:0] nid;
			int          idx;
			int          n;
			int          total;
			r = '0;
			r.last = 1'b1;
			n = 0;
			req_seen[rq]++;
			case (rq)
				REQ_ADD: begin
					r.status = decode_add(chars, len, nid);
					r.new_id = nid;
				end
				REQ_REMOVE: begin
					idx = find_first(cid);
					if (idx < 0) begin
						r.status = ST_NOT_FOUND;
					end else begin
						for (int i = idx; i < count - 1; i++) entries[i] = entries[i + 1];
						count--;
					end
				end
				REQ_ENABLE, REQ_DISABLE: begin
					idx = find_first(cid);
					if (idx < 0) r.status = ST_NOT_FOUND;
					else entries[idx].en = (rq == REQ_ENABLE);
				end
				REQ_VBLANK: begin
					total = 0;
					for (int i = 0; i < count; i++)
						if (entries[i].en) total++;
					if (total > MAX_RESULTS) total = MAX_RESULTS;
					for (int i = 0; i < count && n < total; i++) begin
						if (entries[i].en) begin
							r.action      = entries[i].kind;
							r.bank_number = (entries[i].kind == ACT_WRITE) ? 4'h0 : entries[i].bank;
							r.patch_addr  = entries[i].addr;
							r.patch_value = entries[i].value;
							r.last        = (n == total - 1);
							pending.push_back(r);
							n++;
						end
					end
					patches += n;
				end
				REQ_CLEAR: count = 0;
				default: ;
			endcase
			if (rq != REQ_VBLANK || n == 0) begin
				status_seen[r.status]++;
				pending.push_back(r);
			end
			if (count > peak_fill) peak_fill = count;
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				want = '0;
				report("response with nothing pending", want, got);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.status !== want.status || got.new_id !== want.new_id ||
				got.action !== want.action || got.bank_number !== want.bank_number ||
				got.patch_addr !== want.patch_addr || got.patch_value !== want.patch_value ||
				got.last !== want.last)
				report("response mismatch", want, got);
		endfunction
	endclass

	patch_scoreboard sb;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			observed.status      = status_t'(rsp_if.status);
			observed.new_id      = rsp_if.new_id;
			observed.action      = action_t'(rsp_if.action);
			observed.bank_number = rsp_if.bank_number;
			observed.patch_addr  = rsp_if.patch_addr;
			observed.patch_value = rsp_if.patch_value;
			observed.last        = rsp_if.last;
			sb.check_result(observed);
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send(logic [2:0] rq, logic [63:0] chars, logic [7:0] len,
		logic [31:0] cid);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.req_type    <= rq;
		req_if.code_chars  <= chars;
		req_if.code_length <= len;
		req_if.cheat_id    <= cid;
		do @(posedge clk); while (!req_if.ready);
		sb.note_request(rq, chars, len, cid);
		@(negedge clk);
	endtask

	task automatic drain_responses();
		req_if.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	task automatic random_add();
		logic [63:0] chars;
		logic [7:0]  len;
		logic [7:0]  ty;
		logic [7:0]  junk;
		logic [31:0] body;
		int          pick;
		int          pos;
		pick = $urandom_range(0, 99);
		body = $urandom;
		len  = CODE_LEN;
		case ($urandom_range(0, 2))
			0: ty = TYPE_PLAIN;
			1: ty = {HI_RAM_BANK, 4'($urandom)};
			default: ty = {HI_WRAM_BANK, 4'($urandom)};
		endcase
		if (pick < 16 && pick >= 8) begin
			do ty = 8'($urandom);
			while (ty == TYPE_PLAIN || ty[7:4] == HI_RAM_BANK || ty[7:4] == HI_WRAM_BANK);
		end
		chars = chars_from_nibbles({body[31:8], ty[3:0], ty[7:4]});
		if (pick < 8 && sb.count > 0) begin
			chars = chars_from_nibbles(sb.entries[$urandom_range(0, sb.count - 1)].id);
		end else if (pick >= 16 && pick < 22) begin
			pos = $urandom_range(0, CODE_CHARS - 1);
			do junk = 8'($urandom); while (hex_value(junk) >= 0);
			chars[8*pos +: 8] = junk;
		end else if (pick >= 22 && pick < 27) begin
			do len = 8'($urandom); while (len == CODE_LEN);
		end else if (pick >= 27 && pick < 30) begin
			chars = {$urandom, $urandom};
			len   = $urandom_range(0, 1) ? CODE_LEN : 8'($urandom);
		end
		send(REQ_ADD, chars, len, $urandom);
	endtask

	task automatic random_request(logic heavy);
		int          sel;
		logic [63:0] noise;
		logic [7:0]  noise_len;
		noise     = {$urandom, $urandom};
		noise_len = 8'($urandom);
		if ($urandom_range(0, 99) < (heavy ? 70 : 40)) begin
			random_add();
		end else begin
			sel = $urandom_range(0, 99);
			if (sel < 22) send(REQ_REMOVE, noise, noise_len, sb.pick_id());
			else if (sel < 38) send(REQ_ENABLE, noise, noise_len, sb.pick_id());
			else if (sel < 56) send(REQ_DISABLE, noise, noise_len, sb.pick_id());
			else if (sel < 94) send(REQ_VBLANK, noise, noise_len, $urandom);
			else if (sel < 96) send(REQ_CLEAR, noise, noise_len, $urandom);
			else send($urandom_range(0, 1) ? REQ_UNUSED_7 : REQ_UNUSED_6, noise, noise_len,
				$urandom);
		end
	endtask

	initial begin
		logic [63:0] bad_byte;
		clk                 = 1'b0;
		arst_n              = 1'b0;
		no_idle             = 1'b0;
		cycles              = 0;
		req_if.valid        = 1'b0;
		req_if.req_type     = REQ_ADD;
		req_if.code_chars   = '0;
		req_if.code_length  = '0;
		req_if.cheat_id     = '0;
		rsp_if.ready        = 1'b0;
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table
		send(REQ_VBLANK, '0, '0, '0);
		send(REQ_REMOVE, '0, '0, 32'h0);
		send(REQ_ENABLE, '0, '0, 32'hFFFF_FFFF);
		// parsing
		send(REQ_ADD, pack_text("01000000"), CODE_LEN, '0);
		send(REQ_ADD, pack_text("9FFFFFFF"), CODE_LEN, '1);
		send(REQ_ADD, pack_text("80A51234"), CODE_LEN, '0);
		send(REQ_ADD, pack_text("8fa5b3c1"), CODE_LEN, '0);
		send(REQ_ADD, pack_text("91123456"), CODE_LEN, '0);
		send(REQ_ADD, pack_text("10FF0000"), CODE_LEN, '0);
		send(REQ_ADD, pack_text("a1234567"), CODE_LEN, '0);
		send(REQ_ADD, pack_text("0100000G"), CODE_LEN, '0);
		bad_byte = pack_text("80A51234");
		bad_byte[31:24] = 8'hFF;
		send(REQ_ADD, bad_byte, CODE_LEN, '0);
		send(REQ_ADD, pack_text("01000000"), 8'd7, '0);
		send(REQ_ADD, pack_text("01000000"), 8'd255, '0);
		send(REQ_ADD, pack_text("01000000"), CODE_LEN, '0);
		// lookups and patches
		send(REQ_VBLANK, '0, '0, '0);
		send(REQ_DISABLE, '0, '0, id_of_text("9FFFFFFF"));
		send(REQ_VBLANK, '0, '0, '0);
		send(REQ_ENABLE, '0, '0, id_of_text("9FFFFFFF"));
		send(REQ_REMOVE, '0, '0, id_of_text("01000000"));
		send(REQ_VBLANK, '0, '0, '0);
		send(REQ_UNUSED_6, '1, '1, '1);
		send(REQ_UNUSED_7, '0, '0, '0);
		send(REQ_CLEAR, '0, '0, '0);
		send(REQ_VBLANK, '0, '0, '0);
		drain_responses();

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			no_idle = (k >= 150 && k < 230);
			if (k == 260) drain_responses();
			random_request((k % 100) < 30);
		end
		no_idle = 1'b0;
		drain_responses();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Requests: %0d add, %0d remove, %0d enable, %0d disable, %0d vblank, %0d clear, %0d unused; peak fill %0d/%0d",
			sb.req_seen[REQ_ADD], sb.req_seen[REQ_REMOVE], sb.req_seen[REQ_ENABLE],
			sb.req_seen[REQ_DISABLE], sb.req_seen[REQ_VBLANK], sb.req_seen[REQ_CLEAR],
			sb.req_seen[REQ_UNUSED_6] + sb.req_seen[REQ_UNUSED_7], sb.peak_fill, TABLE_DEPTH);
		$display("Checked %0d transactions: %0d patches, %0d invalid, %0d full, %0d not found; %0d errors",
			sb.checked, sb.patches, sb.status_seen[ST_INVALID], sb.status_seen[ST_FULL],
			sb.status_seen[ST_NOT_FOUND], sb.failures);
		if (sb.failures == 0 && sb.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
